### rtl/psp_pkg.sv
`timescale 1ns / 1ps

package psp_pkg;

  localparam int CMD_W  = 4;
  localparam int PID_W  = 3;
  localparam int SIG_W  = 5;
  localparam int STAT_W = 2;
  localparam int DATA_W = 32;

  localparam logic [SIG_W-1:0] KILL_SIG_RESET = 5'd9;

  typedef enum logic [CMD_W-1:0] {
    CMD_SPAWN      = 4'd0,
    CMD_EXIT       = 4'd1,
    CMD_WAIT       = 4'd2,
    CMD_KILL       = 4'd3,
    CMD_PAUSE      = 4'd4,
    CMD_SEM_LOCK   = 4'd5,
    CMD_SEM_UNLOCK = 4'd6,
    CMD_PIPE_WRITE = 4'd7,
    CMD_PIPE_READ  = 4'd8,
    CMD_WAKE_ALL   = 4'd9
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE    = 2'd0,
    ST_BLOCKED = 2'd1,
    ST_NO_SLOT = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    RS_FREE       = 3'd0,
    RS_READY      = 3'd1,
    RS_WAIT_PROC  = 3'd2,
    RS_BLOCKED    = 3'd3,
    RS_PAUSED     = 3'd4,
    RS_WAIT_READ  = 3'd5,
    RS_WAIT_WRITE = 3'd6
  } run_state_t;

  // One row of the process table.
  typedef struct packed {
    run_state_t       st;
    logic             aw_vld;
    logic [PID_W-1:0] aw_pid;
    logic [SIG_W-1:0] pend;
  } slot_entry_t;

  localparam slot_entry_t SLOT_RESET = '{st: RS_FREE, aw_vld: 1'b0, aw_pid: '0, pend: '0};

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_PREP,
    CS_SWEEP,
    CS_RESULT
  } ctl_state_t;

endpackage

### rtl/psp_ifs.sv
`timescale 1ns / 1ps

interface psp_in_if import psp_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         command;
  logic [PID_W-1:0]         caller_pid;
  logic [PID_W-1:0]         target_slot;
  logic [SIG_W-1:0]         signal_number;
  logic signed [DATA_W-1:0] pipe_data;

  modport source (output valid, command, caller_pid, target_slot, signal_number, pipe_data,
                  input ready);
  modport sink (input valid, command, caller_pid, target_slot, signal_number, pipe_data,
                output ready);
endinterface

interface psp_out_if import psp_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic signed [DATA_W-1:0] read_data;
  logic [PID_W-1:0]         new_pid;

  modport source (output valid, status, read_data, new_pid, input ready);
  modport sink (input valid, status, read_data, new_pid, output ready);
endinterface

### rtl/psp_ram.sv
`timescale 1ns / 1ps

module psp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] q_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = q_r;

endmodule

### rtl/psp_slot_table.sv
`timescale 1ns / 1ps

module psp_slot_table import psp_pkg::*; #(
  parameter int SLOTS = 8,
  localparam int AW = $clog2(SLOTS)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output slot_entry_t   rd_entry,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  slot_entry_t   wr_entry
);

  localparam int EW = $bits(slot_entry_t);

  logic [SLOTS-1:0] vld_r;
  logic             rd_vld_r;
  logic [EW-1:0]    ram_q;

  // A row never written since reset reads as a free slot.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  psp_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_entry),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  assign rd_entry = rd_vld_r ? slot_entry_t'(ram_q) : SLOT_RESET;

endmodule

### rtl/psp_pipe.sv
`timescale 1ns / 1ps

module psp_pipe import psp_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] wdata,
  input  logic              pop,
  output logic [DATA_W-1:0] rdata,
  output logic              full,
  output logic              empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int FW = $clog2(DEPTH + 1);

  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [FW-1:0] fill_r;

  assign full  = (fill_r == FW'(DEPTH));
  assign empty = (fill_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        fill_r <= fill_r + 1'b1;
      end else if (pop && !push) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

  psp_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram (
    .clk     (clk),
    .wr_en   (push),
    .wr_addr (wr_ptr_r),
    .wr_data (wdata),
    .rd_en   (pop),
    .rd_addr (rd_ptr_r),
    .rd_data (rdata)
  );

endmodule

### rtl/process_sync_and_pipe_engine_core.sv
`timescale 1ns / 1ps

// Process synchronisation and pipe engine. Each request carries one command
// (spawn, exit, wait, kill, pause, semaphore lock and unlock, pipe write and
// read, wake all) and yields exactly one result. The process table lives in
// a small synchronous RAM and is swept once per request, one slot per cycle,
// through the single read port of the table. A request goes in order through
// reading the target slot and touching the pipe memory, starting the sweep,
// the sweep itself and handing the result over, which waits while the
// output register holds a result not yet taken. A finished result sits in
// the output register while the next request is accepted. After reset every
// slot is free with no clearing pass, because each table row has a valid
// flag; the pipe memory needs none as only written words are read. The kill
// signal number resets to 9; the user must write it on the cfg_ port only
// while the block is idle, and the block itself does not enforce this.

module process_sync_and_pipe_engine_core import psp_pkg::*; #(
  parameter int PROCESS_SLOTS = 8,
  parameter int PIPE_DEPTH    = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  psp_in_if.sink           in_ch,
  psp_out_if.source        out_ch,
  input  logic             cfg_wr_en,
  input  logic [SIG_W-1:0] cfg_wr_data
);

  localparam int SIDX_W = $clog2(PROCESS_SLOTS);
  localparam logic [SIDX_W-1:0] LAST_SLOT = SIDX_W'(PROCESS_SLOTS - 1);

  ctl_state_t state_r, state_nxt;

  // Request held for the length of the sweep.
  cmd_t              cmd_r;
  logic [PID_W-1:0]  caller_r;
  logic [PID_W-1:0]  target_r;
  logic [SIG_W-1:0]  sig_r;
  logic              caller_ok_r;
  logic              target_ok_r;
  logic              kill_term_r;
  logic              pipe_ok_r;
  logic              pipe_blk_r;
  logic              sem_fail_r;
  logic              tgt_free_r;
  logic              found_r;
  logic [PID_W-1:0]  npid_r;
  logic [DATA_W-1:0] rdata_r;
  logic [SIDX_W-1:0] sw_idx_r;

  logic [SIG_W-1:0]  kill_sig_r;
  logic              sem_r;

  logic              out_valid_r;
  logic [STAT_W-1:0] out_status_r;
  logic [DATA_W-1:0] out_rdata_r;
  logic [PID_W-1:0]  out_npid_r;

  logic              in_rdy;
  logic              accept;
  logic              load_out;
  logic              last_slot;
  cmd_t              in_cmd;
  logic              in_caller_ok;
  logic              in_target_ok;

  logic              tbl_rd_en;
  logic [SIDX_W-1:0] tbl_rd_addr;
  logic              tbl_wr_en;
  slot_entry_t       cur_e;
  slot_entry_t       new_e;
  logic              hit;
  logic              is_caller;
  logic              is_target;
  logic              waits_caller;
  logic              waits_target;

  logic              pipe_push;
  logic              pipe_pop;
  logic              pipe_full;
  logic              pipe_empty;
  logic [DATA_W-1:0] pipe_q;

  status_t           res_status;

  assign in_cmd       = cmd_t'(in_ch.command);
  assign in_caller_ok = (int'(in_ch.caller_pid) < PROCESS_SLOTS);
  assign in_target_ok = (int'(in_ch.target_slot) < PROCESS_SLOTS);
  assign accept       = in_ch.valid && in_rdy;
  assign last_slot    = (sw_idx_r == LAST_SLOT);

  // The pipe is pushed or popped at the moment the request is taken, so the
  // word read is back from the memory by the following cycle.
  assign pipe_push = accept && (in_cmd == CMD_PIPE_WRITE) && in_caller_ok && !pipe_full;
  assign pipe_pop  = accept && (in_cmd == CMD_PIPE_READ) && in_caller_ok && !pipe_empty;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      CS_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = CS_PREP;
        end
      end
      CS_PREP: begin
        state_nxt = CS_SWEEP;
      end
      CS_SWEEP: begin
        if (last_slot) begin
          state_nxt = CS_RESULT;
        end
      end
      CS_RESULT: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = CS_IDLE;
        end
      end
      default: state_nxt = CS_IDLE;
    endcase
  end

  // Controller outputs: request ready, table port addressing and result hand-over.
  always_comb begin
    in_rdy      = 1'b0;
    tbl_rd_en   = 1'b0;
    tbl_rd_addr = '0;
    tbl_wr_en   = 1'b0;
    load_out    = 1'b0;
    unique case (state_r)
      CS_IDLE: begin
        in_rdy      = 1'b1;
        tbl_rd_en   = in_ch.valid;
        tbl_rd_addr = SIDX_W'(in_ch.target_slot);
      end
      CS_PREP: begin
        tbl_rd_en   = 1'b1;
        tbl_rd_addr = '0;
      end
      CS_SWEEP: begin
        tbl_wr_en   = 1'b1;
        tbl_rd_en   = !last_slot;
        tbl_rd_addr = sw_idx_r + 1'b1;
      end
      CS_RESULT: begin
        load_out = !out_valid_r || out_ch.ready;
      end
      default: ;
    endcase
  end

  // Row update during the sweep. The row being written was read in the cycle
  // before and the next read is always a different row, so no forwarding is
  // needed.
  always_comb begin
    new_e        = cur_e;
    hit          = 1'b0;
    is_caller    = caller_ok_r && (sw_idx_r == SIDX_W'(caller_r));
    is_target    = target_ok_r && (sw_idx_r == SIDX_W'(target_r));
    waits_caller = (cur_e.st == RS_WAIT_PROC) && cur_e.aw_vld && (cur_e.aw_pid == caller_r);
    waits_target = (cur_e.st == RS_WAIT_PROC) && cur_e.aw_vld && (cur_e.aw_pid == target_r);
    case (cmd_r)
      CMD_SPAWN: begin
        if (!found_r && (cur_e.st == RS_FREE)) begin
          new_e = '{st: RS_READY, aw_vld: 1'b0, aw_pid: '0, pend: '0};
          hit   = 1'b1;
        end
      end
      CMD_EXIT: begin
        if (is_caller) begin
          new_e.st = RS_FREE;
        end else if (caller_ok_r && waits_caller) begin
          new_e.st     = RS_READY;
          new_e.aw_vld = 1'b0;
        end
      end
      CMD_WAIT: begin
        if (is_caller && target_ok_r && !tgt_free_r) begin
          new_e.st     = RS_WAIT_PROC;
          new_e.aw_pid = target_r;
          new_e.aw_vld = 1'b1;
        end
      end
      CMD_KILL: begin
        if (target_ok_r && !tgt_free_r) begin
          if (kill_term_r) begin
            if (is_target) begin
              new_e.st = RS_FREE;
            end else if (waits_target) begin
              new_e.st     = RS_READY;
              new_e.aw_vld = 1'b0;
            end
          end else if (is_target) begin
            new_e.pend = sig_r;
            if (cur_e.st == RS_PAUSED) begin
              new_e.st = RS_READY;
            end
          end
        end
      end
      CMD_PAUSE: begin
        if (is_caller) begin
          new_e.st = RS_PAUSED;
        end
      end
      CMD_SEM_LOCK: begin
        if (is_caller && sem_fail_r) begin
          new_e.st = RS_BLOCKED;
        end
      end
      CMD_SEM_UNLOCK: begin
        if (!found_r && (cur_e.st == RS_BLOCKED)) begin
          new_e.st = RS_READY;
          hit      = 1'b1;
        end
      end
      CMD_PIPE_WRITE: begin
        if (pipe_ok_r) begin
          if (cur_e.st == RS_WAIT_READ) begin
            new_e.st = RS_READY;
          end
        end else if (is_caller) begin
          new_e.st = RS_WAIT_WRITE;
        end
      end
      CMD_PIPE_READ: begin
        if (pipe_ok_r) begin
          if (cur_e.st == RS_WAIT_WRITE) begin
            new_e.st = RS_READY;
          end
        end else if (is_caller) begin
          new_e.st = RS_WAIT_READ;
        end
      end
      CMD_WAKE_ALL: begin
        if (cur_e.st == RS_BLOCKED) begin
          new_e.st = RS_READY;
        end
      end
      default: ;
    endcase
  end

  // Result status.
  always_comb begin
    res_status = ST_DONE;
    case (cmd_r) inside
      CMD_SPAWN: begin
        if (!found_r) begin
          res_status = ST_NO_SLOT;
        end
      end
      CMD_SEM_LOCK: begin
        if (sem_fail_r) begin
          res_status = ST_BLOCKED;
        end
      end
      CMD_PIPE_WRITE, CMD_PIPE_READ: begin
        if (pipe_blk_r) begin
          res_status = ST_BLOCKED;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= CS_IDLE;
      kill_sig_r  <= KILL_SIG_RESET;
      sem_r       <= 1'b0;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        kill_sig_r <= cfg_wr_data;
      end
      if (accept) begin
        found_r <= 1'b0;
        if ((in_cmd == CMD_SEM_LOCK) && in_caller_ok) begin
          sem_r <= 1'b1;
        end
      end
      if ((state_r == CS_SWEEP) && hit) begin
        found_r <= 1'b1;
      end
      // Unlock with nobody blocked releases the semaphore.
      if (load_out && (cmd_r == CMD_SEM_UNLOCK) && !found_r) begin
        sem_r <= 1'b0;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request and result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r       <= in_cmd;
      caller_r    <= in_ch.caller_pid;
      target_r    <= in_ch.target_slot;
      sig_r       <= in_ch.signal_number;
      caller_ok_r <= in_caller_ok;
      target_ok_r <= in_target_ok;
      kill_term_r <= (in_ch.signal_number == kill_sig_r);
      pipe_ok_r   <= pipe_push || pipe_pop;
      pipe_blk_r  <= in_caller_ok && !(pipe_push || pipe_pop);
      sem_fail_r  <= (in_cmd == CMD_SEM_LOCK) && in_caller_ok && sem_r;
    end
    if (state_r == CS_PREP) begin
      tgt_free_r <= (cur_e.st == RS_FREE);
      rdata_r    <= ((cmd_r == CMD_PIPE_READ) && pipe_ok_r) ? pipe_q : '0;
      sw_idx_r   <= '0;
    end
    if (state_r == CS_SWEEP) begin
      sw_idx_r <= sw_idx_r + 1'b1;
      if (hit) begin
        npid_r <= PID_W'(sw_idx_r);
      end
    end
    if (load_out) begin
      out_status_r <= res_status;
      out_rdata_r  <= rdata_r;
      out_npid_r   <= ((cmd_r == CMD_SPAWN) && found_r) ? npid_r : '0;
    end
  end

  psp_slot_table #(.SLOTS(PROCESS_SLOTS)) u_slots (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (tbl_rd_en),
    .rd_addr  (tbl_rd_addr),
    .rd_entry (cur_e),
    .wr_en    (tbl_wr_en),
    .wr_addr  (sw_idx_r),
    .wr_entry (new_e)
  );

  psp_pipe #(.DEPTH(PIPE_DEPTH)) u_pipe (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (pipe_push),
    .wdata (in_ch.pipe_data),
    .pop   (pipe_pop),
    .rdata (pipe_q),
    .full  (pipe_full),
    .empty (pipe_empty)
  );

  assign in_ch.ready      = in_rdy;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.read_data = out_rdata_r;
  assign out_ch.new_pid   = out_npid_r;

endmodule

### test/process_sync_and_pipe_engine_core_test.sv
`timescale 1ns / 1ps

module process_sync_and_pipe_engine_core_test;
  import psp_pkg::*;

  // The block is built with its default sizes. The expected-result store
  // below keeps a process table and a pipe of the same sizes.
  localparam int PROCESS_SLOTS = 8;
  localparam int PIPE_DEPTH    = 16;

  localparam int RESET_CYCLES   = 9;
  // One request keeps the block busy for its whole sweep, so a short settle
  // after the last result is ample before a register write.
  localparam int SETTLE_CYCLES  = PROCESS_SLOTS + 6;
  localparam int TAIL_CYCLES    = 4 * (PROCESS_SLOTS + 3);
  // The longest quiet stretch in a correct run is one sender gap, one sweep
  // and one receiver stall; the watchdog allows many times that.
  localparam int WATCHDOG_LIMIT = 2000;

  // Command codes above wake all are not defined and must be ignored.
  localparam logic [CMD_W-1:0] CMD_FIRST_UNUSED = CMD_WAKE_ALL + 1'b1;

  // What one request is expected to produce.
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [DATA_W-1:0] read_data;
    logic [PID_W-1:0]  new_pid;
  } call_result_t;

  // Keeps its own copy of the process table, the semaphore and the pipe,
  // works out the result of every accepted request and checks the results
  // that the block returns, oldest first.
  class sync_call_scoreboard;
    run_state_t        slot_state [PROCESS_SLOTS];
    logic              wait_valid [PROCESS_SLOTS];
    logic [PID_W-1:0]  wait_pid   [PROCESS_SLOTS];
    logic [SIG_W-1:0]  pending    [PROCESS_SLOTS];
    logic              sem_held;
    logic [DATA_W-1:0] pipe_mem   [PIPE_DEPTH];
    int unsigned       pipe_wr;
    int unsigned       pipe_rd;
    int unsigned       pipe_words;
    logic [SIG_W-1:0]  kill_sig;
    call_result_t      expected_results [$];
    int unsigned       failures;
    int unsigned       results_seen;
    int unsigned       table_full_spawns;
    int unsigned       pipe_full_writes;
    int unsigned       pipe_empty_reads;
    int unsigned       sem_blocks;

    function new();
      foreach (slot_state[i]) begin
        slot_state[i] = RS_FREE;
        wait_valid[i] = 1'b0;
        wait_pid[i]   = '0;
        pending[i]    = '0;
      end
      sem_held   = 1'b0;
      pipe_wr    = 0;
      pipe_rd    = 0;
      pipe_words = 0;
      kill_sig   = KILL_SIG_RESET;
    endfunction

    function void set_kill_signal(logic [SIG_W-1:0] value);
      kill_sig = value;
    endfunction

    // Every slot that waits on the ended process becomes ready.
    function void release_waiters(logic [PID_W-1:0] ended);
      foreach (slot_state[i]) begin
        if (slot_state[i] == RS_WAIT_PROC && wait_valid[i] && wait_pid[i] == ended) begin
          slot_state[i] = RS_READY;
          wait_valid[i] = 1'b0;
        end
      end
    endfunction

    function void ready_all(run_state_t from);
      foreach (slot_state[i]) begin
        if (slot_state[i] == from) slot_state[i] = RS_READY;
      end
    endfunction

    // A three-bit slot number always lies inside the eight-slot table, so
    // the out-of-range caller and target cases cannot arise here.
    function call_result_t execute_call(logic [CMD_W-1:0] cmd, logic [PID_W-1:0] caller,
                                        logic [PID_W-1:0] target, logic [SIG_W-1:0] sig,
                                        logic [DATA_W-1:0] data);
      call_result_t r;
      logic         handed;
      r = '0;
      handed = 1'b0;
      case (cmd)
        CMD_SPAWN: begin
          r.status = ST_NO_SLOT;
          for (int i = 0; i < PROCESS_SLOTS; i++) begin
            if (slot_state[i] == RS_FREE) begin
              slot_state[i] = RS_READY;
              wait_valid[i] = 1'b0;
              wait_pid[i]   = '0;
              pending[i]    = '0;
              r.status      = ST_DONE;
              r.new_pid     = i[PID_W-1:0];
              break;
            end
          end
          if (r.status == ST_NO_SLOT) table_full_spawns++;
        end
        CMD_EXIT: begin
          slot_state[caller] = RS_FREE;
          release_waiters(caller);
        end
        CMD_WAIT: begin
          if (slot_state[target] != RS_FREE) begin
            slot_state[caller] = RS_WAIT_PROC;
            wait_pid[caller]   = target;
            wait_valid[caller] = 1'b1;
          end
        end
        CMD_KILL: begin
          if (slot_state[target] != RS_FREE) begin
            if (sig == kill_sig) begin
              slot_state[target] = RS_FREE;
              release_waiters(target);
            end else begin
              pending[target] = sig;
              if (slot_state[target] == RS_PAUSED) slot_state[target] = RS_READY;
            end
          end
        end
        CMD_PAUSE: slot_state[caller] = RS_PAUSED;
        CMD_SEM_LOCK: begin
          if (!sem_held) begin
            sem_held = 1'b1;
          end else begin
            slot_state[caller] = RS_BLOCKED;
            r.status = ST_BLOCKED;
            sem_blocks++;
          end
        end
        CMD_SEM_UNLOCK: begin
          for (int i = 0; i < PROCESS_SLOTS; i++) begin
            if (slot_state[i] == RS_BLOCKED) begin
              slot_state[i] = RS_READY;
              handed = 1'b1;
              break;
            end
          end
          if (!handed) sem_held = 1'b0;
        end
        CMD_PIPE_WRITE: begin
          if (pipe_words >= PIPE_DEPTH) begin
            slot_state[caller] = RS_WAIT_WRITE;
            r.status = ST_BLOCKED;
            pipe_full_writes++;
          end else begin
            pipe_mem[pipe_wr] = data;
            pipe_wr = (pipe_wr + 1) % PIPE_DEPTH;
            pipe_words++;
            ready_all(RS_WAIT_READ);
          end
        end
        CMD_PIPE_READ: begin
          if (pipe_words == 0) begin
            slot_state[caller] = RS_WAIT_READ;
            r.status = ST_BLOCKED;
            pipe_empty_reads++;
          end else begin
            r.read_data = pipe_mem[pipe_rd];
            pipe_rd = (pipe_rd + 1) % PIPE_DEPTH;
            pipe_words--;
            ready_all(RS_WAIT_WRITE);
          end
        end
        CMD_WAKE_ALL: ready_all(RS_BLOCKED);
        default: ;
      endcase
      return r;
    endfunction

    function void note_request(logic [CMD_W-1:0] cmd, logic [PID_W-1:0] caller,
                               logic [PID_W-1:0] target, logic [SIG_W-1:0] sig,
                               logic [DATA_W-1:0] data);
      expected_results.push_back(execute_call(cmd, caller, target, sig, data));
    endfunction

    function void check_result(logic [STAT_W-1:0] status, logic [DATA_W-1:0] read_data,
                               logic [PID_W-1:0] new_pid);
      call_result_t want;
      results_seen++;
      if (expected_results.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("[%0t] result with nothing outstanding: status %0d data %h pid %0d",
                   $realtime, status, read_data, new_pid);
        return;
      end
      want = expected_results.pop_front();
      if (want.status !== status || want.read_data !== read_data || want.new_pid !== new_pid) begin
        failures++;
        if (failures <= 10)
          $display("[%0t] result %0d: expected status %0d data %h pid %0d, got %0d %h %0d",
                   $realtime, results_seen, want.status, want.read_data, want.new_pid,
                   status, read_data, new_pid);
      end
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             cfg_wr_en;
  logic [SIG_W-1:0] cfg_wr_data;

  psp_in_if  in_ch ();
  psp_out_if out_ch ();

  process_sync_and_pipe_engine_core #(
    .PROCESS_SLOTS(PROCESS_SLOTS),
    .PIPE_DEPTH   (PIPE_DEPTH)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  sync_call_scoreboard sb = new();

  // idle_on lets both sides insert random gaps and stalls; when it is low the
  // request and result channels run at full rate but for the block's busy states.
  bit               idle_on;
  int unsigned      requests_sent;
  int unsigned      quiet_cycles;
  logic [SIG_W-1:0] kill_sig_now;
  logic [SIG_W-1:0] mid_setting;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sends one request and returns at the clock edge where it is accepted.
  // Valid is left high so that the next request follows without a bubble;
  // it is lowered only for a gap or when the sender waits for the results.
  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [PID_W-1:0] caller,
                              input logic [PID_W-1:0] target, input logic [SIG_W-1:0] sig,
                              input logic [DATA_W-1:0] data);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 12);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.command       <= cmd;
    in_ch.caller_pid    <= caller;
    in_ch.target_slot   <= target;
    in_ch.signal_number <= sig;
    in_ch.pipe_data     <= data;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(cmd, caller, target, sig, data);
    requests_sent++;
  endtask

  // Holds the request channel quiet until every outstanding result is back
  // and the block has had time to return to idle.
  task automatic drain_results;
    in_ch.valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // The kill signal register may only change while the block is idle.
  task automatic write_kill_signal(input logic [SIG_W-1:0] value);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_kill_signal(value);
    kill_sig_now = value;
  endtask

  // At least half of all signals are the one that kills, so that processes
  // end often enough for spawns to find free slots.
  function automatic logic [SIG_W-1:0] pick_signal();
    if ($urandom_range(0, 1) == 0) return kill_sig_now;
    return SIG_W'($urandom_range(0, 2**SIG_W - 1));
  endfunction

  function automatic logic [CMD_W-1:0] pick_command();
    int w;
    w = $urandom_range(0, 99);
    if (w < 16) return CMD_SPAWN;
    if (w < 24) return CMD_EXIT;
    if (w < 32) return CMD_WAIT;
    if (w < 42) return CMD_KILL;
    if (w < 48) return CMD_PAUSE;
    if (w < 56) return CMD_SEM_LOCK;
    if (w < 64) return CMD_SEM_UNLOCK;
    if (w < 78) return CMD_PIPE_WRITE;
    if (w < 92) return CMD_PIPE_READ;
    if (w < 97) return CMD_WAKE_ALL;
    return CMD_W'($urandom_range(CMD_FIRST_UNUSED, 2**CMD_W - 1));
  endfunction

  task automatic random_request(input logic [CMD_W-1:0] cmd);
    send_request(cmd, PID_W'($urandom_range(0, PROCESS_SLOTS - 1)),
                 PID_W'($urandom_range(0, PROCESS_SLOTS - 1)), pick_signal(), $urandom);
  endtask

  // Mixes loose random requests with short sequences that fill and empty the
  // pipe, queue several processes on the semaphore, build wait chains broken
  // by exit or kill, and pause a process that is then sent a signal.
  task automatic random_phase(input int unsigned count, input bit allow_idle);
    int unsigned stop_at;
    int unsigned n;
    logic [PID_W-1:0] a;
    logic [PID_W-1:0] b;
    stop_at = requests_sent + count;
    while (requests_sent < stop_at) begin
      // Idling runs for two stretches of 120 requests out of every three.
      idle_on = allow_idle && ((requests_sent / 120) % 3 != 2);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: random_request(pick_command());
        4, 5: begin
          n = $urandom_range(PIPE_DEPTH - 3, PIPE_DEPTH + 4);
          repeat (n) random_request(CMD_PIPE_WRITE);
          repeat (n + $urandom_range(0, 3)) random_request(CMD_PIPE_READ);
        end
        6: begin
          n = $urandom_range(2, 5);
          repeat (n) random_request(CMD_SEM_LOCK);
          if ($urandom_range(0, 3) == 0) random_request(CMD_WAKE_ALL);
          repeat (n) random_request(CMD_SEM_UNLOCK);
        end
        7, 8: begin
          a = PID_W'($urandom_range(0, PROCESS_SLOTS - 1));
          b = PID_W'($urandom_range(0, PROCESS_SLOTS - 1));
          random_request(CMD_SPAWN);
          random_request(CMD_SPAWN);
          send_request(CMD_WAIT, a, b, '0, $urandom);
          if ($urandom_range(0, 1) == 0) send_request(CMD_EXIT, b, a, '0, $urandom);
          else send_request(CMD_KILL, a, b, pick_signal(), $urandom);
        end
        default: begin
          a = PID_W'($urandom_range(0, PROCESS_SLOTS - 1));
          send_request(CMD_PAUSE, a, a, '0, $urandom);
          send_request(CMD_KILL, a, a, SIG_W'($urandom_range(0, 2**SIG_W - 1)), $urandom);
        end
      endcase
    end
  endtask

  // Directed opening with the reset kill signal: a read on an empty pipe,
  // filling the whole table, words at the data extremes, a wait chain
  // broken by a kill, a wait on a free slot and on the caller itself, the
  // semaphore handed on and freed, a kill of a free slot and the undefined
  // command codes.
  task automatic run_directed;
    send_request(CMD_PIPE_READ, 3'd0, 3'd0, '0, '0);
    repeat (PROCESS_SLOTS) send_request(CMD_SPAWN, 3'd0, 3'd0, '0, '0);
    send_request(CMD_PIPE_WRITE, 3'd5, 3'd0, '0, 32'h8000_0000);
    send_request(CMD_PIPE_WRITE, 3'd6, 3'd0, '0, 32'h7fff_ffff);
    send_request(CMD_PIPE_WRITE, 3'd7, 3'd7, 5'd31, 32'hffff_ffff);
    repeat (3) send_request(CMD_PIPE_READ, 3'd0, 3'd0, '0, '0);
    send_request(CMD_WAIT, 3'd1, 3'd2, '0, '0);
    send_request(CMD_PAUSE, 3'd2, 3'd0, '0, '0);
    send_request(CMD_KILL, 3'd0, 3'd2, 5'd5, '0);
    send_request(CMD_KILL, 3'd0, 3'd2, KILL_SIG_RESET, '0);
    send_request(CMD_WAIT, 3'd3, 3'd2, '0, '0);
    send_request(CMD_WAIT, 3'd4, 3'd4, '0, '0);
    send_request(CMD_KILL, 3'd1, 3'd4, KILL_SIG_RESET, '0);
    send_request(CMD_SEM_LOCK, 3'd1, 3'd0, '0, '0);
    send_request(CMD_SEM_LOCK, 3'd3, 3'd0, '0, '0);
    send_request(CMD_SEM_LOCK, 3'd5, 3'd0, '0, '0);
    send_request(CMD_SEM_UNLOCK, 3'd1, 3'd0, '0, '0);
    send_request(CMD_WAKE_ALL, 3'd0, 3'd0, '0, '0);
    send_request(CMD_SEM_UNLOCK, 3'd3, 3'd0, '0, '0);
    send_request(CMD_EXIT, 3'd7, 3'd7, '0, '0);
    send_request(CMD_KILL, 3'd0, 3'd7, 5'd0, '0);
    send_request(CMD_FIRST_UNUSED, 3'd7, 3'd7, 5'd31, 32'hffff_ffff);
    send_request({CMD_W{1'b1}}, 3'd0, 3'd0, '0, '0);
  endtask

  // Result side: checks every accepted result and stalls in random bursts
  // while idling is allowed.
  initial begin
    int stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready)
        sb.check_result(out_ch.status, out_ch.read_data, out_ch.new_pid);
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 12) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Ends a run that has stopped making progress on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] no request or result moved for %0d cycles", $realtime, WATCHDOG_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n               <= 1'b0;
    cfg_wr_en           <= 1'b0;
    cfg_wr_data         <= KILL_SIG_RESET;
    in_ch.valid         <= 1'b0;
    in_ch.command       <= CMD_SPAWN;
    in_ch.caller_pid    <= '0;
    in_ch.target_slot   <= '0;
    in_ch.signal_number <= '0;
    in_ch.pipe_data     <= '0;
    requests_sent = 0;
    kill_sig_now  = KILL_SIG_RESET;
    idle_on       = 1'b1;
    mid_setting   = SIG_W'($urandom_range(1, 2**SIG_W - 2));

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();

    // Random phases over the smallest, the largest and one middle kill
    // signal, then a last phase at the reset value with no idling at all.
    write_kill_signal('0);
    random_phase(450, 1'b1);
    write_kill_signal({SIG_W{1'b1}});
    random_phase(250, 1'b1);
    // The sender holds off here until every result has come back.
    drain_results();
    random_phase(250, 1'b1);
    write_kill_signal(mid_setting);
    random_phase(450, 1'b1);
    write_kill_signal(KILL_SIG_RESET);
    idle_on = 1'b0;
    random_phase(350, 1'b0);

    in_ch.valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d requests and checked %0d results, kill signal set to 9, 0, 31 and %0d.",
             requests_sent, sb.results_seen, mid_setting);
    $display("Saw %0d spawns on a full table, %0d full-pipe writes, %0d empty-pipe reads, %s",
             sb.table_full_spawns, sb.pipe_full_writes, sb.pipe_empty_reads,
             $sformatf("%0d semaphore blocks.", sb.sem_blocks));
    if (sb.failures == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d results did not match.", sb.failures);
      $display("status: fail");
    end
    $finish;
  end

endmodule
